FILE: sv/mer_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mer_pkg;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam int COLOR_W = 24;
  localparam int CHAN_W  = 8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_R1,
    ST_R2,
    ST_SQ_RX,
    ST_SQ_RY,
    ST_YTERM,
    ST_INIT,
    ST_E_XX,
    ST_E_RYS,
    ST_E_YY,
    ST_E_RXT,
    ST_E_RXRY,
    ST_E_FIN
  } state_t;

  typedef enum logic [3:0] {
    M_NONE,
    M_RX_RX,
    M_RY_RY,
    M_RX2_RY,
    M_X_X1,
    M_PROD_RY2,
    M_YM_YM,
    M_PROD_RX2,
    M_RX2_RY2
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_RX2,
    ACC_RY2,
    ACC_INIT,
    ACC_SEED,
    ACC_ADD,
    ACC_FIN
  } acc_op_t;

  typedef struct packed {
    logic     load;
    logic     step_r1;
    logic     step_r2;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
  } cmd_t;

  typedef struct packed {
    logic r1_leave;
    logic r2_done;
    logic init_flat;
  } sts_t;

endpackage

`default_nettype wire

FILE: sv/mer_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mer_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_op,
  input  wire logic          out_stall,
  input  wire mer_pkg::sts_t sts,
  output mer_pkg::cmd_t      cmd,
  output logic               in_stall,
  output logic               out_valid
);

  mer_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            ready_state;
  logic            accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mer_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign ready_state = (state_r == mer_pkg::ST_IDLE) || (state_r == mer_pkg::ST_R1) ||
                       (state_r == mer_pkg::ST_R2);
  // A request is held off while the multiplier sequence runs or a point waits downstream.
  assign in_stall  = !ready_state || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt   = state_r;
    cmd.load    = 1'b0;
    cmd.step_r1 = 1'b0;
    cmd.step_r2 = 1'b0;
    cmd.mul_sel = mer_pkg::M_NONE;
    cmd.acc_op  = mer_pkg::ACC_NONE;
    unique case (state_r)
      mer_pkg::ST_IDLE, mer_pkg::ST_R1, mer_pkg::ST_R2: begin
        if (accept) begin
          if (in_op == mer_pkg::OP_START) begin
            cmd.load  = 1'b1;
            state_nxt = mer_pkg::ST_SQ_RX;
          end else if (state_r == mer_pkg::ST_R1) begin
            cmd.step_r1 = 1'b1;
            state_nxt   = sts.r1_leave ? mer_pkg::ST_E_XX : mer_pkg::ST_R1;
          end else if (state_r == mer_pkg::ST_R2) begin
            cmd.step_r2 = 1'b1;
            state_nxt   = sts.r2_done ? mer_pkg::ST_IDLE : mer_pkg::ST_R2;
          end
        end
      end
      mer_pkg::ST_SQ_RX: begin
        cmd.mul_sel = mer_pkg::M_RX_RX;
        state_nxt   = mer_pkg::ST_SQ_RY;
      end
      mer_pkg::ST_SQ_RY: begin
        cmd.acc_op  = mer_pkg::ACC_RX2;
        cmd.mul_sel = mer_pkg::M_RY_RY;
        state_nxt   = mer_pkg::ST_YTERM;
      end
      mer_pkg::ST_YTERM: begin
        cmd.acc_op  = mer_pkg::ACC_RY2;
        cmd.mul_sel = mer_pkg::M_RX2_RY;
        state_nxt   = mer_pkg::ST_INIT;
      end
      mer_pkg::ST_INIT: begin
        // A zero radius leaves no region 1, so go straight to the region 2 seed.
        cmd.acc_op = mer_pkg::ACC_INIT;
        state_nxt  = sts.init_flat ? mer_pkg::ST_E_XX : mer_pkg::ST_R1;
      end
      mer_pkg::ST_E_XX: begin
        cmd.mul_sel = mer_pkg::M_X_X1;
        state_nxt   = mer_pkg::ST_E_RYS;
      end
      mer_pkg::ST_E_RYS: begin
        cmd.mul_sel = mer_pkg::M_PROD_RY2;
        state_nxt   = mer_pkg::ST_E_YY;
      end
      mer_pkg::ST_E_YY: begin
        cmd.acc_op  = mer_pkg::ACC_SEED;
        cmd.mul_sel = mer_pkg::M_YM_YM;
        state_nxt   = mer_pkg::ST_E_RXT;
      end
      mer_pkg::ST_E_RXT: begin
        cmd.mul_sel = mer_pkg::M_PROD_RX2;
        state_nxt   = mer_pkg::ST_E_RXRY;
      end
      mer_pkg::ST_E_RXRY: begin
        cmd.acc_op  = mer_pkg::ACC_ADD;
        cmd.mul_sel = mer_pkg::M_RX2_RY2;
        state_nxt   = mer_pkg::ST_E_FIN;
      end
      mer_pkg::ST_E_FIN: begin
        cmd.acc_op = mer_pkg::ACC_FIN;
        state_nxt  = mer_pkg::ST_R2;
      end
      default: begin
        state_nxt = mer_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.step_r1 || cmd.step_r2) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

endmodule

`default_nettype wire

FILE: sv/mer_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module mer_dp #(
  parameter int RADIUS_BITS = 11,
  parameter int COORD_BITS  = 16
) (
  input  wire logic                                 clk,
  input  wire mer_pkg::cmd_t                        cmd,
  input  wire logic signed [COORD_BITS-2:0]         in_center_x,
  input  wire logic signed [COORD_BITS-2:0]         in_center_y,
  input  wire logic        [RADIUS_BITS-1:0]        in_radius_x,
  input  wire logic        [RADIUS_BITS-1:0]        in_radius_y,
  input  wire logic        [mer_pkg::COLOR_W-1:0]   in_color,
  output mer_pkg::sts_t                             sts,
  output logic signed      [COORD_BITS-1:0]         out_x_right,
  output logic signed      [COORD_BITS-1:0]         out_x_left,
  output logic signed      [COORD_BITS-1:0]         out_y_lower,
  output logic signed      [COORD_BITS-1:0]         out_y_upper,
  output logic             [mer_pkg::CHAN_W-1:0]    out_red,
  output logic             [mer_pkg::CHAN_W-1:0]    out_green,
  output logic             [mer_pkg::CHAN_W-1:0]    out_blue,
  output logic                                      out_last_point
);

  localparam int R   = RADIUS_BITS;
  localparam int CB  = COORD_BITS;
  localparam int XW  = R + 1;
  localparam int YW  = R + 2;
  localparam int SQW = 2 * R;
  localparam int OA  = 2 * R + 2;
  localparam int OB  = 2 * R;
  localparam int MW  = OA + OB;
  localparam int DW  = 4 * R + 4;
  localparam int SW  = (CB > R + 2) ? CB + 1 : R + 3;
  localparam int CW  = mer_pkg::CHAN_W;

  logic signed [CB-2:0]              center_col_r;
  logic signed [CB-2:0]              center_row_r;
  logic        [mer_pkg::COLOR_W-1:0] pixel_color_r;
  logic        [R-1:0]               rx_r;
  logic        [R-1:0]               ry_r;
  logic        [SQW-1:0]             rx2_r;
  logic        [SQW-1:0]             ry2_r;
  logic        [XW-1:0]              x_r;
  logic signed [YW-1:0]              y_r;
  logic signed [DW-1:0]              x_term_r;
  logic signed [DW-1:0]              y_term_r;
  logic signed [DW-1:0]              decision_r;
  logic        [DW-1:0]              prod_r;

  logic        [OA-1:0]              mul_a;
  logic        [OB-1:0]              mul_b;
  logic        [MW-1:0]              mul_full;
  logic        [R:0]                 ym_abs;
  logic signed [DW-1:0]              rx2_s;
  logic signed [DW-1:0]              ry2_s;
  logic signed [DW-1:0]              prod_s;
  logic signed [DW-1:0]              xt_inc;
  logic signed [DW-1:0]              yt_dec;
  logic        [XW-1:0]              x_inc;
  logic signed [YW-1:0]              y_dec;
  logic                              dec_neg;
  logic                              dec_pos;

  logic        [XW-1:0]              r1_x, r2_x;
  logic signed [YW-1:0]              r1_y;
  logic signed [DW-1:0]              r1_xt, r1_yt, r1_dec;
  logic signed [DW-1:0]              r2_xt, r2_dec;

  logic signed [SW-1:0]              cx_e, cy_e, ox_e, oy_e;
  logic signed [SW-1:0]              xr_e, xl_e, yl_e, yu_e;

  assign rx2_s  = signed'(DW'(rx2_r));
  assign ry2_s  = signed'(DW'(ry2_r));
  assign prod_s = signed'(prod_r);
  assign xt_inc = x_term_r + (ry2_s <<< 1);
  assign yt_dec = y_term_r - (rx2_s <<< 1);
  assign x_inc  = x_r + XW'(1);
  assign y_dec  = y_r - YW'(1);
  assign dec_neg = decision_r[DW-1];
  assign dec_pos = !decision_r[DW-1] && (decision_r != '0);

  // |y - 1| for the region 2 seed; y is never negative here.
  assign ym_abs = (y_r == '0) ? (R+1)'(1) : (R+1)'(y_dec);

  always_comb begin
    unique case (cmd.mul_sel)
      mer_pkg::M_RX_RX: begin
        mul_a = OA'(rx_r);
        mul_b = OB'(rx_r);
      end
      mer_pkg::M_RY_RY: begin
        mul_a = OA'(ry_r);
        mul_b = OB'(ry_r);
      end
      mer_pkg::M_RX2_RY: begin
        mul_a = OA'(ry_r);
        mul_b = rx2_r;
      end
      mer_pkg::M_X_X1: begin
        mul_a = OA'(x_r) + OA'(1);
        mul_b = OB'(x_r);
      end
      mer_pkg::M_PROD_RY2: begin
        mul_a = prod_r[OA-1:0];
        mul_b = ry2_r;
      end
      mer_pkg::M_YM_YM: begin
        mul_a = OA'(ym_abs);
        mul_b = OB'(ym_abs);
      end
      mer_pkg::M_PROD_RX2: begin
        mul_a = prod_r[OA-1:0];
        mul_b = rx2_r;
      end
      mer_pkg::M_RX2_RY2: begin
        mul_a = OA'(rx2_r);
        mul_b = ry2_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = MW'(mul_a) * MW'(mul_b);

  // Region 1: x always moves, y moves when the decision is not negative.
  always_comb begin
    r1_x  = x_inc;
    r1_xt = xt_inc;
    if (dec_neg) begin
      r1_y   = y_r;
      r1_yt  = y_term_r;
      r1_dec = decision_r + ry2_s + xt_inc;
    end else begin
      r1_y   = y_dec;
      r1_yt  = yt_dec;
      r1_dec = decision_r + ry2_s + xt_inc - yt_dec;
    end
  end

  // Region 2: y always moves, x moves when the decision is not positive.
  always_comb begin
    if (dec_pos) begin
      r2_x   = x_r;
      r2_xt  = x_term_r;
      r2_dec = decision_r + rx2_s - yt_dec;
    end else begin
      r2_x   = x_inc;
      r2_xt  = xt_inc;
      r2_dec = decision_r + rx2_s + xt_inc - yt_dec;
    end
  end

  assign sts.r1_leave  = !(r1_xt < r1_yt);
  assign sts.r2_done   = y_dec[YW-1];
  assign sts.init_flat = (prod_r == '0);

  assign cx_e = SW'(center_col_r);
  assign cy_e = SW'(center_row_r);
  assign ox_e = signed'(SW'(x_r));
  assign oy_e = SW'(y_r);
  assign xr_e = cx_e + ox_e;
  assign xl_e = cx_e - ox_e;
  assign yl_e = cy_e + oy_e;
  assign yu_e = cy_e - oy_e;

  always_ff @(posedge clk) begin
    prod_r <= DW'(mul_full);

    if (cmd.load) begin
      center_col_r  <= in_center_x;
      center_row_r  <= in_center_y;
      pixel_color_r <= in_color;
      rx_r          <= in_radius_x;
      ry_r          <= in_radius_y;
      x_r           <= '0;
      y_r           <= signed'(YW'(in_radius_y));
      x_term_r      <= '0;
    end else if (cmd.step_r1) begin
      x_r        <= r1_x;
      y_r        <= r1_y;
      x_term_r   <= r1_xt;
      y_term_r   <= r1_yt;
      decision_r <= r1_dec;
    end else if (cmd.step_r2) begin
      x_r        <= r2_x;
      y_r        <= y_dec;
      x_term_r   <= r2_xt;
      y_term_r   <= yt_dec;
      decision_r <= r2_dec;
    end

    unique case (cmd.acc_op)
      mer_pkg::ACC_NONE: begin
      end
      mer_pkg::ACC_RX2: begin
        rx2_r <= prod_r[SQW-1:0];
      end
      mer_pkg::ACC_RY2: begin
        ry2_r <= prod_r[SQW-1:0];
      end
      mer_pkg::ACC_INIT: begin
        y_term_r   <= prod_s <<< 1;
        decision_r <= ry2_s - prod_s + (rx2_s >>> 2);
      end
      mer_pkg::ACC_SEED: begin
        decision_r <= prod_s + (ry2_s >>> 2);
      end
      mer_pkg::ACC_ADD: begin
        decision_r <= decision_r + prod_s;
      end
      mer_pkg::ACC_FIN: begin
        decision_r <= decision_r - prod_s;
      end
      default: begin
      end
    endcase

    if (cmd.step_r1 || cmd.step_r2) begin
      out_x_right    <= xr_e[CB-1:0];
      out_x_left     <= xl_e[CB-1:0];
      out_y_lower    <= yl_e[CB-1:0];
      out_y_upper    <= yu_e[CB-1:0];
      out_red        <= pixel_color_r[3*CW-1:2*CW];
      out_green      <= pixel_color_r[2*CW-1:CW];
      out_blue       <= pixel_color_r[CW-1:0];
      out_last_point <= cmd.step_r2 && sts.r2_done;
    end
  end

endmodule

`default_nettype wire

FILE: sv/midpoint_ellipse_raster_top.sv
// Channel  | Ports                                          | Handshake
// input    | in_op, in_center_x/y, in_radius_x/y, in_color  | in_valid / in_stall
// result   | out_x_right/left, out_y_lower/upper, out_red,  | out_valid / out_stall
//          | out_green, out_blue, out_last_point            |
// A step's point shows in the cycle after acceptance, one point per cycle unless stalled.
// A start sets up on the shared multiplier, and also seeds region 2 if a radius is zero.
// The change from region 1 to region 2 runs ST_E_XX to ST_E_FIN on that multiplier.
// Reset (rst_n low, synchronous) returns the block to idle with no point pending.
// A stall on the result side holds the point and stalls the input side.
`timescale 1ns / 1ps
`default_nettype none

module midpoint_ellipse_raster_top #(
  parameter int RADIUS_BITS = 11,
  parameter int COORD_BITS  = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               in_op,
  input  wire logic signed [COORD_BITS-2:0]       in_center_x,
  input  wire logic signed [COORD_BITS-2:0]       in_center_y,
  input  wire logic        [RADIUS_BITS-1:0]      in_radius_x,
  input  wire logic        [RADIUS_BITS-1:0]      in_radius_y,
  input  wire logic        [mer_pkg::COLOR_W-1:0] in_color,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed      [COORD_BITS-1:0]       out_x_right,
  output logic signed      [COORD_BITS-1:0]       out_x_left,
  output logic signed      [COORD_BITS-1:0]       out_y_lower,
  output logic signed      [COORD_BITS-1:0]       out_y_upper,
  output logic             [mer_pkg::CHAN_W-1:0]  out_red,
  output logic             [mer_pkg::CHAN_W-1:0]  out_green,
  output logic             [mer_pkg::CHAN_W-1:0]  out_blue,
  output logic                                    out_last_point
);

  mer_pkg::cmd_t cmd;
  mer_pkg::sts_t sts;

  mer_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  mer_dp #(
    .RADIUS_BITS (RADIUS_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .in_center_x    (in_center_x),
    .in_center_y    (in_center_y),
    .in_radius_x    (in_radius_x),
    .in_radius_y    (in_radius_y),
    .in_color       (in_color),
    .sts            (sts),
    .out_x_right    (out_x_right),
    .out_x_left     (out_x_left),
    .out_y_lower    (out_y_lower),
    .out_y_upper    (out_y_upper),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_last_point (out_last_point)
  );

  a_start_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_op == mer_pkg::OP_START)) |=> in_stall)
    else $error("start request did not hold off the next request");

  a_step_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step_r1 || cmd.step_r2) |-> !(out_valid && out_stall))
    else $error("point taken while the result register is still occupied");

  a_step_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step_r1 || cmd.step_r2) |=> out_valid)
    else $error("stepped point not presented");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.step_r1, cmd.step_r2}))
    else $error("more than one request action at once");

  a_mul_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mul_sel != mer_pkg::M_NONE) |-> (in_stall && !cmd.load))
    else $error("request accepted during multiplier sequence");

endmodule

`default_nettype wire

FILE: bench/midpoint_ellipse_raster_top_tb.sv
`timescale 1ns / 1ps

module midpoint_ellipse_raster_top_tb;

  localparam int RADIUS_BITS  = 11;
  localparam int COORD_BITS   = 16;
  localparam int CEN_BITS     = COORD_BITS - 1;
  localparam int LONG_HOLD    = 160;
  localparam int DRAIN_CYCLES = 40;
  localparam int NO_CAP       = 100000;

  typedef struct packed {
    logic signed [COORD_BITS-1:0]  x_right;
    logic signed [COORD_BITS-1:0]  x_left;
    logic signed [COORD_BITS-1:0]  y_lower;
    logic signed [COORD_BITS-1:0]  y_upper;
    logic [mer_pkg::CHAN_W-1:0]    red;
    logic [mer_pkg::CHAN_W-1:0]    green;
    logic [mer_pkg::CHAN_W-1:0]    blue;
    logic                          last_point;
  } ellipse_point_t;

  logic                          clk         = 1'b0;
  logic                          rst_n       = 1'b0;
  logic                          in_valid    = 1'b0;
  logic                          in_stall;
  logic                          in_op       = mer_pkg::OP_STEP;
  logic signed [COORD_BITS-2:0]  in_center_x = '0;
  logic signed [COORD_BITS-2:0]  in_center_y = '0;
  logic [RADIUS_BITS-1:0]        in_radius_x = '0;
  logic [RADIUS_BITS-1:0]        in_radius_y = '0;
  logic [mer_pkg::COLOR_W-1:0]   in_color    = '0;
  logic                          out_valid;
  logic                          out_stall   = 1'b0;
  logic signed [COORD_BITS-1:0]  out_x_right;
  logic signed [COORD_BITS-1:0]  out_x_left;
  logic signed [COORD_BITS-1:0]  out_y_lower;
  logic signed [COORD_BITS-1:0]  out_y_upper;
  logic [mer_pkg::CHAN_W-1:0]    out_red;
  logic [mer_pkg::CHAN_W-1:0]    out_green;
  logic [mer_pkg::CHAN_W-1:0]    out_blue;
  logic                          out_last_point;

  midpoint_ellipse_raster_top #(
    .RADIUS_BITS(RADIUS_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_center_x   (in_center_x),
    .in_center_y   (in_center_y),
    .in_radius_x   (in_radius_x),
    .in_radius_y   (in_radius_y),
    .in_color      (in_color),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_x_right   (out_x_right),
    .out_x_left    (out_x_left),
    .out_y_lower   (out_y_lower),
    .out_y_upper   (out_y_upper),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_last_point(out_last_point)
  );

  always #5 clk = ~clk;

  // Traced ellipse: the expected state of the block after each accepted request.
  mer_pkg::state_t             trace_phase = mer_pkg::ST_IDLE;
  longint                      trace_cx    = 0;
  longint                      trace_cy    = 0;
  logic [mer_pkg::COLOR_W-1:0] trace_color = '0;
  longint                      rx_sq       = 0;
  longint                      ry_sq       = 0;
  longint                      off_x       = 0;
  longint                      off_y       = 0;
  longint                      x_term      = 0;
  longint                      y_term      = 0;
  longint                      decision    = 0;

  ellipse_point_t pending_points[$];

  int  starts_sent      = 0;
  int  points_predicted = 0;
  int  points_checked   = 0;
  int  last_points      = 0;
  int  idle_steps       = 0;
  int  wide_starts      = 0;
  int  long_holds_done  = 0;
  int  mismatches       = 0;
  int  gap_percent      = 10;
  int  stall_percent    = 8;
  bit  steady_run       = 1'b0;
  bit  long_hold_asked  = 1'b0;

  // Region 1 hands over to region 2 once the slope reaches one; region 2 ends below the axis.
  function void settle_region();
    longint ym1;
    if (trace_phase == mer_pkg::ST_R1 && !(x_term < y_term)) begin
      ym1         = off_y - 1;
      trace_phase = mer_pkg::ST_R2;
      decision    = ry_sq * (off_x * off_x + off_x) + (ry_sq >>> 2)
                  + rx_sq * ym1 * ym1 - rx_sq * ry_sq;
    end
    if (trace_phase == mer_pkg::ST_R2 && off_y < 0) begin
      trace_phase = mer_pkg::ST_IDLE;
    end
  endfunction

  function void predict_request(input logic op,
                                input logic signed [COORD_BITS-2:0] cx,
                                input logic signed [COORD_BITS-2:0] cy,
                                input logic [RADIUS_BITS-1:0] rx,
                                input logic [RADIUS_BITS-1:0] ry,
                                input logic [mer_pkg::COLOR_W-1:0] col);
    ellipse_point_t pt;
    longint rxl;
    longint ryl;
    if (op == mer_pkg::OP_START) begin
      rxl         = longint'(rx);
      ryl         = longint'(ry);
      trace_cx    = longint'(cx);
      trace_cy    = longint'(cy);
      trace_color = col;
      rx_sq       = rxl * rxl;
      ry_sq       = ryl * ryl;
      off_x       = 0;
      off_y       = ryl;
      x_term      = 0;
      y_term      = 2 * rx_sq * ryl;
      decision    = ry_sq - rx_sq * ryl + (rx_sq >>> 2);
      trace_phase = mer_pkg::ST_R1;
      settle_region();
      starts_sent++;
      if (rx[RADIUS_BITS-1] || ry[RADIUS_BITS-1]) begin
        wide_starts++;
      end
    end else if (trace_phase == mer_pkg::ST_IDLE) begin
      idle_steps++;
    end else begin
      pt.x_right = COORD_BITS'(trace_cx + off_x);
      pt.x_left  = COORD_BITS'(trace_cx - off_x);
      pt.y_lower = COORD_BITS'(trace_cy + off_y);
      pt.y_upper = COORD_BITS'(trace_cy - off_y);
      pt.red     = trace_color[23:16];
      pt.green   = trace_color[15:8];
      pt.blue    = trace_color[7:0];
      if (trace_phase == mer_pkg::ST_R1) begin
        off_x++;
        x_term += 2 * ry_sq;
        if (decision < 0) begin
          decision += ry_sq + x_term;
        end else begin
          off_y--;
          y_term -= 2 * rx_sq;
          decision += ry_sq + x_term - y_term;
        end
      end else begin
        off_y--;
        y_term -= 2 * rx_sq;
        if (decision > 0) begin
          decision += rx_sq - y_term;
        end else begin
          off_x++;
          x_term += 2 * ry_sq;
          decision += rx_sq + x_term - y_term;
        end
      end
      settle_region();
      pt.last_point = (trace_phase == mer_pkg::ST_IDLE);
      if (pt.last_point) begin
        last_points++;
      end
      points_predicted++;
      pending_points.push_back(pt);
    end
  endfunction

  // Valid stays high from one request to the next unless a gap is drawn.
  task automatic send_request(input logic op,
                              input logic signed [COORD_BITS-2:0] cx,
                              input logic signed [COORD_BITS-2:0] cy,
                              input logic [RADIUS_BITS-1:0] rx,
                              input logic [RADIUS_BITS-1:0] ry,
                              input logic [mer_pkg::COLOR_W-1:0] col);
    if (!steady_run && $urandom_range(0, 99) < gap_percent) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_center_x <= cx;
    in_center_y <= cy;
    in_radius_x <= rx;
    in_radius_y <= ry;
    in_color    <= col;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(op, cx, cy, rx, ry, col);
  endtask

  // A step request carries random junk in the fields that it does not use.
  task automatic send_step();
    send_request(mer_pkg::OP_STEP, CEN_BITS'($urandom), CEN_BITS'($urandom),
                 RADIUS_BITS'($urandom), RADIUS_BITS'($urandom),
                 mer_pkg::COLOR_W'($urandom));
  endtask

  task automatic send_start(input logic signed [COORD_BITS-2:0] cx,
                            input logic signed [COORD_BITS-2:0] cy,
                            input logic [RADIUS_BITS-1:0] rx,
                            input logic [RADIUS_BITS-1:0] ry,
                            input logic [mer_pkg::COLOR_W-1:0] col);
    send_request(mer_pkg::OP_START, cx, cy, rx, ry, col);
  endtask

  task automatic walk_ellipse(input int max_points);
    int n;
    n = 0;
    while (trace_phase != mer_pkg::ST_IDLE && n < max_points) begin
      send_step();
      n++;
    end
  endtask

  task automatic test_idle_steps();
    repeat (3) send_step();
  endtask

  task automatic test_extremes();
    send_start(CEN_BITS'(-16384), CEN_BITS'(16383), RADIUS_BITS'(2047), RADIUS_BITS'(2047),
               24'hFFFFFF);
    walk_ellipse(4);
    // A new start here drops the ellipse that is still running.
    send_start(CEN_BITS'(16383), CEN_BITS'(-16384), RADIUS_BITS'(0), RADIUS_BITS'(2047),
               24'h000000);
    walk_ellipse(3);
    send_start(CEN_BITS'(-1), CEN_BITS'(0), RADIUS_BITS'(2047), RADIUS_BITS'(0), 24'hA55AC3);
    walk_ellipse(2);
    send_step();
    send_start(CEN_BITS'(0), CEN_BITS'(-1), RADIUS_BITS'(0), RADIUS_BITS'(0), 24'h5AA53C);
    walk_ellipse(2);
    send_step();
  endtask

  task automatic test_full_small();
    send_start(CEN_BITS'(7), CEN_BITS'(-9), RADIUS_BITS'(3), RADIUS_BITS'(2), 24'h12C3F0);
    walk_ellipse(NO_CAP);
  endtask

  task automatic test_random_ellipses(input int target);
    int stop_at;
    int cap;
    int kind;
    logic [RADIUS_BITS-1:0] rx;
    logic [RADIUS_BITS-1:0] ry;
    stop_at = starts_sent + points_predicted + target;
    while (starts_sent + points_predicted < stop_at) begin
      case ($urandom_range(0, 2))
        0: gap_percent = 0;
        1: gap_percent = 10;
        default: gap_percent = 35;
      endcase
      case ($urandom_range(0, 2))
        0: stall_percent = 0;
        1: stall_percent = 5;
        default: stall_percent = 15;
      endcase
      kind = $urandom_range(0, 99);
      cap  = NO_CAP;
      if (kind < 6) begin
        // Full-range radii would take thousands of points, so only the start of the walk is kept.
        rx  = RADIUS_BITS'($urandom_range(0, 2047));
        ry  = RADIUS_BITS'($urandom_range(0, 2047));
        cap = $urandom_range(8, 48);
      end else if (kind < 10) begin
        rx = RADIUS_BITS'($urandom_range(16, 90));
        ry = RADIUS_BITS'($urandom_range(16, 90));
      end else begin
        rx = RADIUS_BITS'($urandom_range(0, 15));
        ry = RADIUS_BITS'($urandom_range(0, 15));
      end
      send_start(CEN_BITS'($urandom), CEN_BITS'($urandom), rx, ry,
                 mer_pkg::COLOR_W'($urandom));
      if ($urandom_range(0, 9) == 0) begin
        cap = $urandom_range(0, 5);
      end
      walk_ellipse(cap);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) send_step();
      end
    end
  endtask

  // The result side holds off while requests keep coming, so the block backs up.
  task automatic test_backpressure();
    gap_percent     = 0;
    long_hold_asked = 1'b1;
    send_start(CEN_BITS'(100), CEN_BITS'(-100), RADIUS_BITS'(30), RADIUS_BITS'(20),
               24'h3366CC);
    walk_ellipse(60);
  endtask

  initial begin
    forever begin
      if (long_hold_asked) begin
        long_hold_asked = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_holds_done++;
      end else if (!steady_run && $urandom_range(0, 99) < stall_percent) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_points
    ellipse_point_t expected_pt;
    ellipse_point_t seen_pt;
    if (rst_n && out_valid && !out_stall) begin
      seen_pt = '{out_x_right, out_x_left, out_y_lower, out_y_upper,
                  out_red, out_green, out_blue, out_last_point};
      if (pending_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: point with nothing expected: x %0d/%0d y %0d/%0d", $realtime,
                   seen_pt.x_right, seen_pt.x_left, seen_pt.y_lower, seen_pt.y_upper);
        end
      end else begin
        expected_pt = pending_points.pop_front();
        points_checked++;
        if (seen_pt !== expected_pt) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: point %0d wrong", $realtime, points_checked);
            $display("  expected x %0d/%0d y %0d/%0d rgb %h %h %h last %b",
                     expected_pt.x_right, expected_pt.x_left, expected_pt.y_lower,
                     expected_pt.y_upper, expected_pt.red, expected_pt.green,
                     expected_pt.blue, expected_pt.last_point);
            $display("  actual   x %0d/%0d y %0d/%0d rgb %h %h %h last %b",
                     seen_pt.x_right, seen_pt.x_left, seen_pt.y_lower, seen_pt.y_upper,
                     seen_pt.red, seen_pt.green, seen_pt.blue, seen_pt.last_point);
          end
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_steps();
    test_extremes();
    test_full_small();
    test_random_ellipses(1450);
    test_backpressure();
    steady_run = 1'b1;
    test_random_ellipses(250);
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d ellipse starts (%0d with a radius of 1024 or more) and %0d points,",
             starts_sent, wide_starts, points_checked);
    $display("%0d of them final, %0d steps while idle, %0d long output hold(s); %0d mismatches.",
             last_points, idle_steps, long_holds_done, mismatches);
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Run did not complete in time, %0d points still outstanding.",
             pending_points.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: sim.f
sv/mer_pkg.sv
sv/mer_ctrl.sv
sv/mer_dp.sv
sv/midpoint_ellipse_raster_top.sv
bench/midpoint_ellipse_raster_top_tb.sv
